// ===== design/assert_macros.svh =====
// Assertion helpers for the design files; hti_cell.sv includes them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, held off while reset is asserted.
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Next-cycle implication, held off while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

// ===== design/hti_pkg.sv =====
package hti_pkg;

	localparam int ZOOM_W  = 5;
	localparam int COORD_W = 26;
	localparam int ID_W    = 53;
	localparam int OFF_W   = 64;

	typedef struct packed {
		logic [ZOOM_W-1:0]  zoom;
		logic [COORD_W-1:0] x;
		logic [COORD_W-1:0] y;
	} hti_item_t;

	// Count of tiles at all lower zooms, (4^z - 1) / 3: every even bit below 2z set.
	function automatic logic [OFF_W-1:0] zoom_offset(input logic [ZOOM_W-1:0] z);
		logic [OFF_W-1:0] off;
		off = '0;
		for (int i = 0; i < OFF_W / 2; i++) begin
			if (ZOOM_W'(i) < z) begin
				off[2*i] = 1'b1;
			end
		end
		return off;
	endfunction

endpackage

// ===== design/hti_cell.sv =====
`include "assert_macros.svh"

module hti_cell import hti_pkg::*; #(
	parameter int LEVEL = 0,
	parameter int H_W   = 2
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  hti_item_t      in_item,
	input  logic [H_W-1:0] in_h,
	output logic           out_valid,
	input  logic           out_ready,
	output hti_item_t      out_item,
	output logic [H_W-1:0] out_h
);

	localparam logic [COORD_W-1:0] LOW_M = (LEVEL >= COORD_W) ? {COORD_W{1'b1}} :
		COORD_W'((64'd1 << LEVEL) - 64'd1);

	logic               v_q;
	hti_item_t          item_q;
	logic [H_W-1:0]     h_q;
	logic               active;
	logic               bx_raw;
	logic               by_raw;
	logic               bx;
	logic               by;
	logic [COORD_W-1:0] xm;
	logic [COORD_W-1:0] ym;
	logic [COORD_W-1:0] xr;
	logic [COORD_W-1:0] yr;
	hti_item_t          item_n;
	logic [H_W-1:0]     h_n;

	generate
		if (LEVEL < COORD_W) begin : g_bits
			assign bx_raw = in_item.x[LEVEL];
			assign by_raw = in_item.y[LEVEL];
		end else begin : g_zero
			assign bx_raw = 1'b0;
			assign by_raw = 1'b0;
		end
	endgenerate

	// only levels below the zoom take part
	assign active = in_item.zoom > ZOOM_W'(LEVEL);
	assign bx     = active & bx_raw;
	assign by     = active & by_raw;

	always_comb begin
		xm = in_item.x & LOW_M;
		ym = in_item.y & LOW_M;
		if (bx) begin
			xr = ~xm & LOW_M;
			yr = ~ym & LOW_M;
		end else begin
			xr = xm;
			yr = ym;
		end
		item_n = in_item;
		h_n    = in_h;
		if (active) begin
			h_n[2*LEVEL +: 2] = {bx, bx ^ by};
			if (!by) begin
				item_n.x = yr;
				item_n.y = xr;
			end else begin
				item_n.x = xm;
				item_n.y = ym;
			end
		end
	end

	assign in_ready = !v_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else if (in_ready) begin
			v_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_q <= item_n;
			h_q    <= h_n;
		end
	end

	assign out_valid = v_q;
	assign out_item  = item_q;
	assign out_h     = h_q;

	`ASSERT_NEXT(a_idle_keeps_h, clk, arst_n, in_valid && in_ready && !active, h_q == $past(in_h))
	`ASSERT_NEXT(a_high_bits_clear, clk, arst_n, in_valid && in_ready && active, ((item_q.x | item_q.y) & ~LOW_M) == '0)
	`ASSERT_NEXT(a_code_lands, clk, arst_n, in_valid && in_ready, (h_q[2*LEVEL+1] == $past(bx)) && (h_q[2*LEVEL] == $past(bx ^ by)))

endmodule

// ===== design/hilbert_tile_id_top.sv =====
// An accepted input transaction passes every level cell, then the output register.
// Throughput: one transaction per cycle; each level cell and the output register
// hold one transaction and advance when the next stage is empty or advancing.
// Reset: arst_n clears every valid flag at once; payload registers are not reset.
// No stored state beyond the pipeline, so no clearing pass after reset.
module hilbert_tile_id_top import hti_pkg::*; #(
	parameter int MAX_ZOOM = 26
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [63:0] s_tdata,  // [4:0] zoom, [30:5] tile_x, [56:31] tile_y, zero pad
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [55:0] m_tdata   // [52:0] tile_id, zero pad
);

	localparam int NC  = MAX_ZOOM;
	localparam int H_W = 2 * MAX_ZOOM;

	// Handshake and payload between cells; index 0 is the input, NC the last cell.
	logic           v   [0:NC];
	logic           rdy [0:NC];
	hti_item_t      item[0:NC];
	logic [H_W-1:0] h   [0:NC];

	logic [ZOOM_W-1:0] zoom_in;
	logic [ZOOM_W-1:0] zoom_sat;
	logic              out_v_q;
	logic [ID_W-1:0]   tile_id_q;

	// Unpack the input and clamp the zoom to the largest level the chain holds.
	assign zoom_in  = s_tdata[4:0];
	assign zoom_sat = (zoom_in > ZOOM_W'(MAX_ZOOM)) ? ZOOM_W'(MAX_ZOOM) : zoom_in;
	assign item[0]  = {zoom_sat, s_tdata[30:5], s_tdata[56:31]};

	assign h[0]     = '0;
	assign v[0]     = s_tvalid;
	assign s_tready = rdy[0];

	// One cell per coordinate bit, top bit first. A cell above the zoom passes
	// its transaction through untouched; the others add their quadrant code and
	// reflect or swap the remaining low bits for the next cell.
	generate
		for (genvar k = 0; k < NC; k++) begin : g_cell
			hti_cell #(
				.LEVEL(NC - 1 - k),
				.H_W  (H_W)
			) u_cell (
				.clk      (clk),
				.arst_n   (arst_n),
				.in_valid (v[k]),
				.in_ready (rdy[k]),
				.in_item  (item[k]),
				.in_h     (h[k]),
				.out_valid(v[k+1]),
				.out_ready(rdy[k+1]),
				.out_item (item[k+1]),
				.out_h    (h[k+1])
			);
		end
	endgenerate

	// Output register: add the lower-zoom tile count to the curve index and
	// hold the result until the downstream side takes it.
	assign rdy[NC] = !out_v_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (rdy[NC]) begin
			out_v_q <= v[NC];
		end
	end

	always_ff @(posedge clk) begin
		if (v[NC] && rdy[NC]) begin
			tile_id_q <= ID_W'(OFF_W'(h[NC]) + zoom_offset(item[NC].zoom));
		end
	end

	assign m_tvalid = out_v_q;
	assign m_tdata  = {{(56 - ID_W){1'b0}}, tile_id_q};

endmodule
